// ----- design/rclm_pkg.sv -----
// ----------------------------------------------------------------------------
// rclm_pkg
// Shared widths, register indexes, reset values, types and helpers for the
// relay close latency meter.
// ----------------------------------------------------------------------------
package rclm_pkg;

   localparam int TIMER_W    = 24;
   localparam int DEB_W      = 16;
   localparam int CNT_W      = 8;
   localparam int SUM_W      = 32;
   localparam int IDX_W      = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

   // register indexes
   localparam logic [IDX_W-1:0] REG_TOGGLE_PERIOD = 2'd0;
   localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 2'd1;
   localparam logic [IDX_W-1:0] REG_TRIALS        = 2'd2;

   // register reset values
   localparam logic [TIMER_W-1:0] TOGGLE_PERIOD_RST = 24'd1000000;
   localparam logic [DEB_W-1:0]   DEBOUNCE_RST      = 16'd2000;
   localparam logic [CNT_W-1:0]   TRIALS_RST        = 8'd10;

   typedef struct packed {
      logic [TIMER_W-1:0] toggle_period_us;
      logic [DEB_W-1:0]   debounce_us;
      logic [CNT_W-1:0]   trials_per_batch;
   } cfg_type;

   typedef struct packed {
      logic               relay_drive;
      logic               trial_valid;
      logic [TIMER_W-1:0] delay_us;
      logic [CNT_W-1:0]   trial_number;
      logic               batch_done;
      logic [SUM_W-1:0]   batch_sum_us;
   } rsp_type;

   // count one tick, hold at full scale
   function automatic logic [TIMER_W-1:0] tick_up(input logic [TIMER_W-1:0] t);
      tick_up = (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
   endfunction

endpackage

// ----- design/rclm_if.sv -----
// ----------------------------------------------------------------------------
// rclm_if
// Valid/ready channels of the relay close latency meter: tick input,
// result output and register write port.
// ----------------------------------------------------------------------------
interface rclm_req_if;
   logic valid;
   logic ready;
   logic contact_edge;

   modport source (output valid, output contact_edge, input ready);
   modport sink   (input valid, input contact_edge, output ready);
endinterface

interface rclm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        relay_drive;
   logic                        trial_valid;
   logic [rclm_pkg::TIMER_W-1:0] delay_us;
   logic [rclm_pkg::CNT_W-1:0]   trial_number;
   logic                        batch_done;
   logic [rclm_pkg::SUM_W-1:0]   batch_sum_us;

   modport source (output valid, output relay_drive, output trial_valid,
                   output delay_us, output trial_number, output batch_done,
                   output batch_sum_us, input ready);
   modport sink   (input valid, input relay_drive, input trial_valid,
                   input delay_us, input trial_number, input batch_done,
                   input batch_sum_us, output ready);
endinterface

interface rclm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rclm_pkg::IDX_W-1:0]      index;
   logic [rclm_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- design/rclm_csr.sv -----
// ----------------------------------------------------------------------------
// rclm_csr
// Configuration register file: toggle period, debounce time and batch size.
// ----------------------------------------------------------------------------
module rclm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_valid,
   input  logic [rclm_pkg::IDX_W-1:0]      wr_index,
   input  logic [rclm_pkg::CSR_DATA_W-1:0] wr_data,
   output rclm_pkg::cfg_type               cfg
);

   rclm_pkg::cfg_type cfg_ff;
   rclm_pkg::cfg_type cfg_in;

   // decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            rclm_pkg::REG_TOGGLE_PERIOD: cfg_in.toggle_period_us = wr_data;
            rclm_pkg::REG_DEBOUNCE:
               cfg_in.debounce_us = wr_data[rclm_pkg::DEB_W-1:0];
            rclm_pkg::REG_TRIALS:
               cfg_in.trials_per_batch = wr_data[rclm_pkg::CNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.toggle_period_us <= rclm_pkg::TOGGLE_PERIOD_RST;
         cfg_ff.debounce_us      <= rclm_pkg::DEBOUNCE_RST;
         cfg_ff.trials_per_batch <= rclm_pkg::TRIALS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/rclm_core.sv -----
// ----------------------------------------------------------------------------
// rclm_core
// Tick pipeline: input register, one pass of debounce, drive toggle and
// delay measurement against the state, then the result register.
// ----------------------------------------------------------------------------
module rclm_core (
   input  logic              clock,
   input  logic              reset,
   input  rclm_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  logic              in_edge,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output rclm_pkg::rsp_type out_data
);

   localparam int LIM_W = rclm_pkg::CNT_W + 1;

   // input register
   logic in_valid_ff;
   logic in_edge_ff;

   // state
   logic [rclm_pkg::TIMER_W-1:0] since_edge_ff,      since_edge_in;
   logic                         edge_pending_ff,    edge_pending_in;
   logic                         drive_level_ff,     drive_level_in;
   logic [rclm_pkg::TIMER_W-1:0] since_toggle_ff,    since_toggle_in;
   logic [rclm_pkg::TIMER_W-1:0] since_drive_low_ff, since_drive_low_in;
   logic [rclm_pkg::CNT_W-1:0]   trial_count_ff,     trial_count_in;
   logic [rclm_pkg::SUM_W-1:0]   delay_sum_ff,       delay_sum_in;

   // result register
   logic              out_valid_ff;
   rclm_pkg::rsp_type out_data_ff, out_data_in;

   logic                         out_free;
   logic                         consume;
   logic [rclm_pkg::TIMER_W-1:0] se_inc, st_inc, sdl_inc;
   logic [rclm_pkg::TIMER_W-1:0] deb_ext;
   logic                         edge_acc, toggle, goes_low;
   logic                         pend_a, pend_b, measure, trial;
   logic [LIM_W-1:0]             next_cnt, limit;
   logic [rclm_pkg::SUM_W:0]     sum_wide;
   logic [rclm_pkg::SUM_W-1:0]   sum_sat;
   logic                         done;

   // handshake: the result slot frees when empty or taken this cycle
   assign out_free = !out_valid_ff || out_ready;
   assign consume  = in_valid_ff && out_free;
   assign in_ready = !in_valid_ff || out_free;

   // one tick of work
   always_comb begin
      deb_ext = {{(rclm_pkg::TIMER_W-rclm_pkg::DEB_W){1'b0}}, cfg.debounce_us};
      se_inc  = rclm_pkg::tick_up(since_edge_ff);
      st_inc  = rclm_pkg::tick_up(since_toggle_ff);
      sdl_inc = rclm_pkg::tick_up(since_drive_low_ff);

      // debounce the contact edge
      edge_acc      = in_edge_ff && (se_inc > deb_ext);
      pend_a        = edge_acc || edge_pending_ff;
      since_edge_in = edge_acc ? '0 : se_inc;

      // toggle the drive; going low clears the pending edge and the timer
      toggle             = (st_inc >= cfg.toggle_period_us);
      since_toggle_in    = toggle ? '0 : st_inc;
      drive_level_in     = toggle ? !drive_level_ff : drive_level_ff;
      goes_low           = toggle && drive_level_ff;
      pend_b             = goes_low ? 1'b0 : pend_a;
      since_drive_low_in = goes_low ? '0 : sdl_inc;

      // measure a pending edge while driven low
      measure         = pend_b && !drive_level_in;
      edge_pending_in = measure ? 1'b0 : pend_b;
      trial           = measure && (since_drive_low_in >= deb_ext);

      next_cnt = {1'b0, trial_count_ff} + 1'b1;
      limit    = (cfg.trials_per_batch == '0) ? LIM_W'(1 << rclm_pkg::CNT_W)
                                              : {1'b0, cfg.trials_per_batch};
      sum_wide = {1'b0, delay_sum_ff} +
                 {{(rclm_pkg::SUM_W+1-rclm_pkg::TIMER_W){1'b0}}, since_drive_low_in};
      sum_sat  = sum_wide[rclm_pkg::SUM_W] ? rclm_pkg::SUM_MAX
                                           : sum_wide[rclm_pkg::SUM_W-1:0];
      done     = trial && (next_cnt >= limit);

      trial_count_in = trial_count_ff;
      delay_sum_in   = delay_sum_ff;
      if (trial) begin
         trial_count_in = done ? '0 : next_cnt[rclm_pkg::CNT_W-1:0];
         delay_sum_in   = done ? '0 : sum_sat;
      end

      out_data_in.relay_drive  = drive_level_in;
      out_data_in.trial_valid  = trial;
      out_data_in.delay_us     = trial ? since_drive_low_in : '0;
      out_data_in.trial_number = trial ? next_cnt[rclm_pkg::CNT_W-1:0] : '0;
      out_data_in.batch_done   = done;
      out_data_in.batch_sum_us = done ? sum_sat : '0;
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         since_edge_ff      <= '0;
         edge_pending_ff    <= 1'b0;
         drive_level_ff     <= 1'b1;
         since_toggle_ff    <= '0;
         since_drive_low_ff <= '0;
         trial_count_ff     <= '0;
         delay_sum_ff       <= '0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (consume) begin
            since_edge_ff      <= since_edge_in;
            edge_pending_ff    <= edge_pending_in;
            drive_level_ff     <= drive_level_in;
            since_toggle_ff    <= since_toggle_in;
            since_drive_low_ff <= since_drive_low_in;
            trial_count_ff     <= trial_count_in;
            delay_sum_ff       <= delay_sum_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_edge_ff <= in_edge;
      end
      if (consume) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- design/relay_close_latency_meter.sv -----
// ----------------------------------------------------------------------------
// relay_close_latency_meter
// Relay close latency meter: debounces contact edges, toggles the relay
// drive, measures drive-to-close delays and reports batch sums.
// ----------------------------------------------------------------------------
// A tick is held in the input register, and its result in the result
// register until it is transferred.
// Throughput: one tick per cycle while results are taken, set by the
// single-pass update of the timer and trial state between the registers.
// Reset (synchronous): drive high, timers, count and sum zero, registers
// at their defaults; the register write port is always ready.
module relay_close_latency_meter (
   input  logic        clock,
   input  logic        reset,
   rclm_req_if.sink    req,
   rclm_rsp_if.source  rsp,
   rclm_csr_if.sink    csr
);

   rclm_pkg::cfg_type cfg;
   rclm_pkg::rsp_type rsp_data;

   assign csr.ready = 1'b1;

   rclm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.wdata),
      .cfg      (cfg)
   );

   rclm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_edge   (req.contact_edge),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp_data)
   );

   assign rsp.relay_drive  = rsp_data.relay_drive;
   assign rsp.trial_valid  = rsp_data.trial_valid;
   assign rsp.delay_us     = rsp_data.delay_us;
   assign rsp.trial_number = rsp_data.trial_number;
   assign rsp.batch_done   = rsp_data.batch_done;
   assign rsp.batch_sum_us = rsp_data.batch_sum_us;

   // a batch only completes on an accepted trial
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.batch_done |-> rsp.trial_valid)
      else $error("batch_done without trial_valid");

   // no trial means zero delay and trial number
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.trial_valid |-> rsp.delay_us == '0 && rsp.trial_number == '0)
      else $error("delay fields set without a trial");

   // sum is shown only with batch_done
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.batch_done |-> rsp.batch_sum_us == '0)
      else $error("batch sum set without batch_done");

   // input side is open right after reset
   assert property (@(posedge clock)
      reset |=> req.ready)
      else $error("input not ready after reset");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the relay close latency meter. Drives microsecond ticks with
// random contact edges through the valid/ready input channel, predicts each
// tick's drive level, trial and batch result, and checks every result
// transfer field by field. Registers are rewritten between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [rclm_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_REPORTS    = 10;
   localparam int REPORT_W       = rclm_pkg::SUM_W;
   localparam int LIMIT_W        = rclm_pkg::CNT_W + 1;

   logic clock = 1'b0;
   logic reset;

   rclm_req_if req_if ();
   rclm_rsp_if rsp_if ();
   rclm_csr_if csr_if ();

   relay_close_latency_meter uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always #1 clock = ~clock;

   // predicted state of the meter
   rclm_pkg::cfg_type            meter_cfg;
   logic [rclm_pkg::TIMER_W-1:0] since_edge;
   logic                         edge_armed;
   logic                         drive_level;
   logic [rclm_pkg::TIMER_W-1:0] since_toggle;
   logic [rclm_pkg::TIMER_W-1:0] since_drive_low;
   logic [rclm_pkg::CNT_W-1:0]   trials_done;
   logic [rclm_pkg::SUM_W-1:0]   delay_total;

   rclm_pkg::rsp_type pending_results[$];
   int      mismatch_count = 0;
   int      result_count   = 0;
   int      idle_cycles    = 0;
   bit      req_stall_on   = 1'b0;
   bit      rsp_stall_on   = 1'b0;

   // return the meter to its power-up state
   task automatic reset_meter_state();
      meter_cfg.toggle_period_us = rclm_pkg::TOGGLE_PERIOD_RST;
      meter_cfg.debounce_us      = rclm_pkg::DEBOUNCE_RST;
      meter_cfg.trials_per_batch = rclm_pkg::TRIALS_RST;
      since_edge      = '0;
      edge_armed      = 1'b0;
      drive_level     = 1'b1;
      since_toggle    = '0;
      since_drive_low = '0;
      trials_done     = '0;
      delay_total     = '0;
   endtask

   // advance the meter by one tick and form the tick's result
   task automatic advance_meter(input logic contact, output rclm_pkg::rsp_type res);
      logic [rclm_pkg::CNT_W:0]     next_count;
      logic [rclm_pkg::CNT_W:0]     batch_limit;
      logic [rclm_pkg::SUM_W:0]     wide_sum;
      logic [rclm_pkg::TIMER_W-1:0] lockout;
      res = '0;
      lockout = {{(rclm_pkg::TIMER_W-rclm_pkg::DEB_W){1'b0}}, meter_cfg.debounce_us};
      if (since_edge != rclm_pkg::TIMER_MAX) since_edge++;
      if (since_toggle != rclm_pkg::TIMER_MAX) since_toggle++;
      if (since_drive_low != rclm_pkg::TIMER_MAX) since_drive_low++;

      // accept the edge only after the lockout has run out
      if (contact && since_edge > lockout) begin
         edge_armed = 1'b1;
         since_edge = '0;
      end

      // toggle the drive; going low drops a pending edge and restarts timing
      if (since_toggle >= meter_cfg.toggle_period_us) begin
         since_toggle = '0;
         drive_level  = ~drive_level;
         if (!drive_level) begin
            edge_armed      = 1'b0;
            since_drive_low = '0;
         end
      end

      // measure; short delays are consumed without a trial
      if (edge_armed && !drive_level) begin
         edge_armed = 1'b0;
         if (since_drive_low >= lockout) begin
            next_count  = {1'b0, trials_done} + 1'b1;
            batch_limit = (meter_cfg.trials_per_batch == '0) ? LIMIT_W'(256) :
                          {1'b0, meter_cfg.trials_per_batch};
            res.trial_valid  = 1'b1;
            res.delay_us     = since_drive_low;
            res.trial_number = next_count[rclm_pkg::CNT_W-1:0];
            wide_sum    = {1'b0, delay_total} +
                          {{(rclm_pkg::SUM_W+1-rclm_pkg::TIMER_W){1'b0}}, since_drive_low};
            delay_total = wide_sum[rclm_pkg::SUM_W] ? rclm_pkg::SUM_MAX
                                                    : wide_sum[rclm_pkg::SUM_W-1:0];
            if (next_count >= batch_limit) begin
               res.batch_done   = 1'b1;
               res.batch_sum_us = delay_total;
               delay_total      = '0;
               trials_done      = '0;
            end else begin
               trials_done = next_count[rclm_pkg::CNT_W-1:0];
            end
         end
      end
      res.relay_drive = drive_level;
   endtask

   // mirror a register write; unknown indexes are dropped
   task automatic apply_register(input logic [rclm_pkg::IDX_W-1:0] idx,
                                 input logic [rclm_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         rclm_pkg::REG_TOGGLE_PERIOD:
            meter_cfg.toggle_period_us = value[rclm_pkg::TIMER_W-1:0];
         rclm_pkg::REG_DEBOUNCE:
            meter_cfg.debounce_us      = value[rclm_pkg::DEB_W-1:0];
         rclm_pkg::REG_TRIALS:
            meter_cfg.trials_per_batch = value[rclm_pkg::CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic note_field(input string field, input logic [REPORT_W-1:0] want,
                             input logic [REPORT_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("result %0d: %s expected %0d, got %0d", result_count, field, want, got);
   endtask

   task automatic compare_result(input rclm_pkg::rsp_type want,
                                 input rclm_pkg::rsp_type got);
      if (got.relay_drive !== want.relay_drive)
         note_field("relay_drive", REPORT_W'(want.relay_drive),
                    REPORT_W'(got.relay_drive));
      if (got.trial_valid !== want.trial_valid)
         note_field("trial_valid", REPORT_W'(want.trial_valid),
                    REPORT_W'(got.trial_valid));
      if (got.delay_us !== want.delay_us)
         note_field("delay_us", REPORT_W'(want.delay_us), REPORT_W'(got.delay_us));
      if (got.trial_number !== want.trial_number)
         note_field("trial_number", REPORT_W'(want.trial_number),
                    REPORT_W'(got.trial_number));
      if (got.batch_done !== want.batch_done)
         note_field("batch_done", REPORT_W'(want.batch_done), REPORT_W'(got.batch_done));
      if (got.batch_sum_us !== want.batch_sum_us)
         note_field("batch_sum_us", want.batch_sum_us, got.batch_sum_us);
   endtask

   // check results, predict ticks and track register writes at each edge
   always @(posedge clock) begin
      rclm_pkg::rsp_type got;
      rclm_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.relay_drive  = rsp_if.relay_drive;
            got.trial_valid  = rsp_if.trial_valid;
            got.delay_us     = rsp_if.delay_us;
            got.trial_number = rsp_if.trial_number;
            got.batch_done   = rsp_if.batch_done;
            got.batch_sum_us = rsp_if.batch_sum_us;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d: transfer with no tick outstanding", result_count);
            end else begin
               want = pending_results.pop_front();
               compare_result(want, got);
            end
            result_count++;
         end
         if (req_if.valid && req_if.ready) begin
            advance_meter(req_if.contact_edge, want);
            pending_results.push_back(want);
         end
         if (csr_if.valid && csr_if.ready)
            apply_register(csr_if.index, csr_if.wdata);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic int draw_gap(input bit enabled);
      draw_gap = enabled ? int'($urandom_range(13, 0)) : 0;
   endfunction

   // result side: when stalls are on, hold off a random number of cycles before each transfer
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = draw_gap(rsp_stall_on);
         @(negedge clock);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // present one tick and hold it until the transfer
   task automatic send_tick(input logic contact);
      int gap;
      gap = draw_gap(req_stall_on);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.contact_edge <= contact;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // drop the tick stream and wait for every outstanding result
   task automatic settle_meter();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rclm_pkg::IDX_W-1:0] idx,
                            input logic [rclm_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // idle the block, then write all three registers, with junk in the unused bits of the debounce and trials writes
   task automatic configure_meter(input logic [rclm_pkg::TIMER_W-1:0] period,
                                  input logic [rclm_pkg::DEB_W-1:0] lockout,
                                  input logic [rclm_pkg::CNT_W-1:0] batch);
      logic [31:0] noise;
      settle_meter();
      noise = $urandom;
      write_reg(rclm_pkg::REG_TOGGLE_PERIOD, period);
      write_reg(rclm_pkg::REG_DEBOUNCE, {noise[7:0], lockout});
      write_reg(rclm_pkg::REG_TRIALS, {noise[31:16], batch});
   endtask

   // defaults: long period and lockout, so the drive stays high
   task automatic test_reset_defaults();
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // short period: lockout, edge dropped on going low, short delay
   task automatic test_measure_cases();
      logic [15:0] pattern;
      pattern = 16'b1100_1011_0100_1110;
      configure_meter(24'd3, 16'd2, 8'd2);
      for (int i = 15; i >= 0; i--) send_tick(pattern[i]);

      // toggle every tick; an edge never survives the drive going low
      configure_meter(24'd0, 16'd0, 8'd3);
      repeat (4) send_tick(1'b1);
   endtask

   task automatic test_register_extremes();
      logic [31:0] noise;
      settle_meter();
      noise = $urandom;
      write_reg(rclm_pkg::REG_TOGGLE_PERIOD, rclm_pkg::TIMER_MAX);
      write_reg(rclm_pkg::REG_DEBOUNCE, {8'hFF, 16'hFFFF});
      write_reg(rclm_pkg::REG_TRIALS, {16'hFFFF, 8'hFF});
      write_reg(REG_UNUSED, noise[rclm_pkg::CSR_DATA_W-1:0]);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // build up a count in a large batch, then lower the batch size below it
   task automatic test_lowered_limit();
      configure_meter(24'd8, 16'd0, 8'd200);
      repeat (24) send_tick(1'b1);
      settle_meter();
      write_reg(rclm_pkg::REG_TRIALS, {16'h5A5A, 8'd2});
      repeat (12) send_tick(1'b1);
   endtask

   task automatic test_random_phases();
      logic [rclm_pkg::TIMER_W-1:0] period;
      logic [rclm_pkg::DEB_W-1:0]   lockout;
      logic [rclm_pkg::CNT_W-1:0]   batch;
      logic [31:0]                  draw;
      int                           edge_pct;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(5, 0))
            0:       period = '0;
            1:       period = 24'd1;
            default: begin
               draw   = $urandom_range(40, 2);
               period = draw[rclm_pkg::TIMER_W-1:0];
            end
         endcase
         draw     = $urandom_range(period / 2 + 2, 0);
         lockout  = ($urandom_range(3, 0) == 0) ? '0 : draw[rclm_pkg::DEB_W-1:0];
         draw     = $urandom_range(5, 1);
         batch    = ($urandom_range(7, 0) == 0) ? 8'd255 : draw[rclm_pkg::CNT_W-1:0];
         edge_pct = $urandom_range(90, 10);
         configure_meter(period, lockout, batch);
         req_stall_on = (phase != 0) && $urandom_range(1, 0);
         rsp_stall_on = (phase != 0) && $urandom_range(1, 0);
         repeat (60) send_tick($urandom_range(99, 0) < edge_pct);
      end
   endtask

   // batch size zero runs to 256 trials; one full drive cycle of low ticks
   task automatic test_full_batch();
      configure_meter(24'd265, 16'd0, 8'd0);
      req_stall_on = 1'b1;
      rsp_stall_on = 1'b1;
      repeat (530) send_tick(1'b1);
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.contact_edge = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.wdata        = '0;
      reset_meter_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_measure_cases();
      test_register_extremes();
      test_lowered_limit();
      test_random_phases();
      test_full_batch();

      settle_meter();
      mismatch_count += pending_results.size();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
